@@ sv/phase_addressed_cv_recorder_assert.svh @@
// Assertion macros for the phase-addressed CV recorder.
// Included by the top level; relies on nothing else.
`ifndef PHASE_ADDRESSED_CV_RECORDER_ASSERT_SVH
`define PHASE_ADDRESSED_CV_RECORDER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PACR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PACR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/pacr_pkg.sv @@
// Shared types and constants of the phase-addressed CV recorder.
// No dependencies; used by the controller, datapath, divider and top level.
`timescale 1ns / 1ps
`default_nettype none

package pacr_pkg;

	localparam int CV_W      = 16;
	localparam int PHASE_W   = 16;
	localparam int ROW_W     = 2;
	localparam int PLAY_W    = 10;
	localparam int CMD_W     = 2;
	localparam int DIV_W     = 7;
	localparam int MASK_W    = 4;
	localparam int DIV_REGS  = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIV_W-1:0] DIV_MIN = 7'd1;
	localparam logic [DIV_W-1:0] DIV_MAX = 7'd64;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BAKE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIV0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WMASK = 3'd4;

	typedef enum logic [1:0] {
		SW_CLEAR,
		SW_BAKE,
		SW_REBUILD
	} sweep_op_t;

	typedef struct packed {
		logic      latch_item;
		logic      init_clear;
		logic      sample_write;
		logic      div_start;
		logic      sweep_en;
		sweep_op_t sweep_op;
		logic      set_last_div;
		logic      read_idx;
		logic      load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             row_ok;
		logic             rebuild_needed;
		logic             sweep_last;
		logic             div_busy;
		logic             init_last;
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/phase_addressed_cv_recorder.sv @@
// Top level of the phase-addressed CV recorder: controller plus datapath.
// Depends on pacr_pkg, pacr_ctrl, pacr_dp and the assertion macro header.
//
// Usage:
//   Request channel (item_valid / item_stall) carries command, row, phase,
//   cv_sample and write_gate. Sample access (command 0) yields one result on
//   the result channel (result_valid / result_stall); clear, bake, command 3
//   and rows at or beyond ROWS yield none.
//   Config port (cfg_we, cfg_index, cfg_data) writes divide_row0..3 at
//   indexes 0..3 and write_enable_mask at index 4; write only while idle.
//   Timing: one request at a time. A sample access passes the decode, write,
//   read and output states, raising result_valid once the result register is
//   loaded, and the next request is taken after that; one that needs an overlay
//   rebuild also runs the divider and then a sweep over the record/overlay
//   memory ports. Clear and bake hold the request side while they sweep the
//   row, one memory entry per cycle.
//   Reset: both memories are swept to zero, all ROWS * 2^clog2(SAMPLES) entries
//   (4096 at the defaults), with item_stall high; config writes still land.
//   The result register holds while result_stall is high; a new request is
//   accepted meanwhile, and its result waits until the register is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "phase_addressed_cv_recorder_assert.svh"

module phase_addressed_cv_recorder #(
	parameter int SAMPLES = 1024,
	parameter int ROWS    = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [pacr_pkg::CMD_W-1:0]       command,
	input  wire logic [pacr_pkg::ROW_W-1:0]       row,
	input  wire logic [pacr_pkg::PHASE_W-1:0]     phase,
	input  wire logic signed [pacr_pkg::CV_W-1:0] cv_sample,
	input  wire logic                             write_gate,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic [pacr_pkg::ROW_W-1:0]            out_row,
	output logic [pacr_pkg::PLAY_W-1:0]           play_index,
	output logic signed [pacr_pkg::CV_W-1:0]      record_value,
	output logic signed [pacr_pkg::CV_W-1:0]      overlay_value,
	input  wire logic                             cfg_we,
	input  wire logic [pacr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pacr_pkg::DIV_W-1:0]       cfg_data
);

	pacr_pkg::dp_cmd_t    cmd;
	pacr_pkg::dp_status_t status;

	// sequencing: init sweep, decode, write, divide, sweep, read, output
	pacr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// memories, counters, divider and the result register
	pacr_dp #(
		.SAMPLES (SAMPLES),
		.ROWS    (ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.row           (row),
		.phase         (phase),
		.cv_sample     (cv_sample),
		.write_gate    (write_gate),
		.out_row       (out_row),
		.play_index    (play_index),
		.record_value  (record_value),
		.overlay_value (overlay_value)
	);

	// accepted request must take the block busy on the next cycle
	`PACR_ASSERT_NEXT(a_accept_busy, clk, arst_n, item_valid && !item_stall, item_stall, "request accepted but block not busy")
	// loading the result register must raise result_valid
	`PACR_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, result_valid, "result load did not raise valid")
	// divider must be running right after a rebuild is started
	`PACR_ASSERT_NEXT(a_div_runs, clk, arst_n, cmd.div_start, status.div_busy, "divider not busy after start")
	// record writes from a sample access only for an existing row
	`PACR_ASSERT_SAME(a_write_row, clk, arst_n, cmd.sample_write, status.row_ok, "sample write on a missing row")

endmodule

`default_nettype wire

@@ sv/pacr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the overlay segment length.
// Uses pacr_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none

module pacr_div #(
	parameter int NW = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [NW-1:0]              numer,
	input  wire logic [pacr_pkg::DIV_W-1:0] denom,
	output logic                            busy,
	output logic [NW-1:0]                   quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]              num_q;
	logic [NW-1:0]              quot_q;
	logic [pacr_pkg::DIV_W-1:0] rem_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic [pacr_pkg::DIV_W:0]   trial;
	logic [pacr_pkg::DIV_W:0]   diff;
	logic                       ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, denom};
	assign ge    = (trial >= {1'b0, denom});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= numer;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= ge ? diff[pacr_pkg::DIV_W-1:0] : trial[pacr_pkg::DIV_W-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

@@ sv/pacr_ctrl.sv @@
// Controller of the CV recorder: sequences init clear, sample access,
// overlay rebuild, clear and bake. Uses pacr_pkg command/status types.
`timescale 1ns / 1ps
`default_nettype none

module pacr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	input  wire pacr_pkg::dp_status_t status,
	output pacr_pkg::dp_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_DIV,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_OUT
	} state_t;

	state_t              state_q;
	pacr_pkg::sweep_op_t op_q;
	logic                result_valid_q;
	logic                out_free;

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		cmd          = '0;
		cmd.sweep_op = op_q;
		case (state_q)
			ST_INIT:  cmd.init_clear = 1'b1;
			ST_IDLE:  cmd.latch_item = item_valid;
			ST_WRITE: begin
				cmd.sample_write = 1'b1;
				cmd.div_start    = status.rebuild_needed;
			end
			ST_SWEEP: cmd.sweep_en = 1'b1;
			ST_DRAIN: cmd.set_last_div = (op_q == pacr_pkg::SW_REBUILD);
			ST_READ:  cmd.read_idx = 1'b1;
			ST_OUT:   cmd.load_out = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			op_q           <= pacr_pkg::SW_CLEAR;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end
			case (state_q)
				ST_INIT: begin
					if (status.init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (!status.row_ok) begin
						state_q <= ST_IDLE;
					end else begin
						case (status.command)
							pacr_pkg::CMD_SAMPLE: state_q <= ST_WRITE;
							pacr_pkg::CMD_CLEAR: begin
								op_q    <= pacr_pkg::SW_CLEAR;
								state_q <= ST_SWEEP;
							end
							pacr_pkg::CMD_BAKE: begin
								op_q    <= pacr_pkg::SW_BAKE;
								state_q <= ST_SWEEP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: begin
					if (status.rebuild_needed) begin
						op_q    <= pacr_pkg::SW_REBUILD;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DIV: begin
					if (!status.div_busy) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (status.sweep_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (op_q == pacr_pkg::SW_REBUILD) ? ST_READ : ST_IDLE;
				end
				ST_READ: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

@@ sv/pacr_dp.sv @@
// Datapath of the CV recorder: config registers, record and overlay memories,
// sweep counters and output register. Uses pacr_pkg and pacr_div.
`timescale 1ns / 1ps
`default_nettype none

module pacr_dp #(
	parameter int SAMPLES = 1024,
	parameter int ROWS    = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pacr_pkg::dp_cmd_t               cmd,
	output pacr_pkg::dp_status_t                 status,
	input  wire logic                            cfg_we,
	input  wire logic [pacr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pacr_pkg::DIV_W-1:0]      cfg_data,
	input  wire logic [pacr_pkg::CMD_W-1:0]      command,
	input  wire logic [pacr_pkg::ROW_W-1:0]      row,
	input  wire logic [pacr_pkg::PHASE_W-1:0]    phase,
	input  wire logic signed [pacr_pkg::CV_W-1:0] cv_sample,
	input  wire logic                            write_gate,
	output logic [pacr_pkg::ROW_W-1:0]           out_row,
	output logic [pacr_pkg::PLAY_W-1:0]          play_index,
	output logic signed [pacr_pkg::CV_W-1:0]     record_value,
	output logic signed [pacr_pkg::CV_W-1:0]     overlay_value
);

	localparam int IW    = $clog2(SAMPLES);
	localparam int QW    = $clog2(SAMPLES + 1);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW    = RW + IW;
	localparam int DEPTH = ROWS * (2 ** IW);
	localparam int PW    = pacr_pkg::PHASE_W + QW;

	localparam logic [IW-1:0] J_LAST   = IW'(SAMPLES - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	// configuration
	logic [pacr_pkg::DIV_W-1:0]  divide_q [pacr_pkg::DIV_REGS];
	logic [pacr_pkg::MASK_W-1:0] wmask_q;
	logic [pacr_pkg::DIV_W-1:0]  last_div_q [ROWS];
	logic [pacr_pkg::DIV_W-1:0]  div_raw;
	logic [pacr_pkg::DIV_W-1:0]  eff_div;

	// latched request
	logic [pacr_pkg::CMD_W-1:0] command_q;
	logic [pacr_pkg::ROW_W-1:0] row_q;
	logic [pacr_pkg::PHASE_W-1:0] phase_q;
	logic [pacr_pkg::CV_W-1:0]  cv_q;
	logic                       gate_q;
	logic [RW-1:0]              row_idx;
	logic [PW-1:0]              prod;
	logic [IW-1:0]              idx_q;

	// sweep
	logic [IW-1:0]   j_q;
	logic [QW-1:0]   k_q;
	logic [QW-1:0]   k_inc;
	logic [QW-1:0]   seg_len;
	logic            valid_s1;
	pacr_pkg::sweep_op_t op_s1;
	logic [IW-1:0]   j_s1;
	logic            start_s1;
	logic [pacr_pkg::CV_W-1:0] v_q;
	logic [pacr_pkg::CV_W-1:0] seg_val;
	logic [AW-1:0]   clr_addr_q;
	logic            div_busy;

	// memories
	logic [pacr_pkg::CV_W-1:0] rec_mem [DEPTH];
	logic [pacr_pkg::CV_W-1:0] ovl_mem [DEPTH];
	logic [pacr_pkg::CV_W-1:0] rec_rdata;
	logic [pacr_pkg::CV_W-1:0] ovl_rdata;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      rec_we;
	logic [AW-1:0]             rec_waddr;
	logic [pacr_pkg::CV_W-1:0] rec_wdata;
	logic                      ovl_we;
	logic [AW-1:0]             ovl_waddr;
	logic [pacr_pkg::CV_W-1:0] ovl_wdata;
	logic                      samp_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pacr_pkg::DIV_REGS; i++) begin
				divide_q[i] <= pacr_pkg::DIV_MIN;
			end
			wmask_q <= '1;
		end else if (cfg_we) begin
			if (cfg_index inside {[pacr_pkg::CFG_DIV0:pacr_pkg::CFG_DIV3]}) begin
				divide_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == pacr_pkg::CFG_WMASK) begin
				wmask_q <= cfg_data[pacr_pkg::MASK_W-1:0];
			end
		end
	end

	// zero acts as one, anything above the maximum acts as the maximum
	assign div_raw = divide_q[row_q];
	always_comb begin
		if (div_raw < pacr_pkg::DIV_MIN) begin
			eff_div = pacr_pkg::DIV_MIN;
		end else if (div_raw > pacr_pkg::DIV_MAX) begin
			eff_div = pacr_pkg::DIV_MAX;
		end else begin
			eff_div = div_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			command_q <= command;
			row_q     <= row;
			phase_q   <= phase;
			cv_q      <= cv_sample;
			gate_q    <= write_gate;
		end
		idx_q <= prod[pacr_pkg::PHASE_W +: IW];
	end

	assign row_idx = RW'(row_q);
	assign prod    = PW'(phase_q) * PW'(SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				last_div_q[r] <= '0;
			end
		end else if (cmd.set_last_div) begin
			last_div_q[row_idx] <= eff_div;
		end
	end

	pacr_div #(.NW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (QW'(SAMPLES)),
		.denom  (eff_div),
		.busy   (div_busy),
		.quot   (seg_len)
	);

	// sweep position and offset within the current segment
	assign k_inc = k_q + QW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			k_q        <= '0;
			valid_s1   <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			valid_s1 <= cmd.sweep_en;
			if (cmd.sweep_en) begin
				if (j_q == J_LAST) begin
					j_q <= '0;
					k_q <= '0;
				end else begin
					j_q <= j_q + IW'(1);
					k_q <= (k_inc == seg_len) ? '0 : k_inc;
				end
			end
			if (cmd.init_clear) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= cmd.sweep_op;
		j_s1     <= j_q;
		start_s1 <= (k_q == '0);
		if (valid_s1 && start_s1) begin
			v_q <= rec_rdata;
		end
	end

	// a segment starting on the last entry is not written
	assign seg_val = start_s1 ? rec_rdata : v_q;
	assign samp_we = cmd.sample_write && gate_q && wmask_q[row_q];

	always_comb begin
		rec_we    = 1'b0;
		rec_waddr = {row_idx, j_q};
		rec_wdata = '0;
		if (cmd.init_clear) begin
			rec_we    = 1'b1;
			rec_waddr = clr_addr_q;
		end else if (samp_we) begin
			rec_we    = 1'b1;
			rec_waddr = {row_idx, idx_q};
			rec_wdata = cv_q;
		end else if (cmd.sweep_en && cmd.sweep_op == pacr_pkg::SW_CLEAR) begin
			rec_we = 1'b1;
		end else if (valid_s1 && op_s1 == pacr_pkg::SW_BAKE) begin
			rec_we    = 1'b1;
			rec_waddr = {row_idx, j_s1};
			rec_wdata = ovl_rdata;
		end
	end

	always_comb begin
		ovl_we    = 1'b0;
		ovl_waddr = {row_idx, j_q};
		ovl_wdata = '0;
		if (cmd.init_clear) begin
			ovl_we    = 1'b1;
			ovl_waddr = clr_addr_q;
		end else if (cmd.sweep_en && cmd.sweep_op == pacr_pkg::SW_CLEAR) begin
			ovl_we = 1'b1;
		end else if (valid_s1 && op_s1 == pacr_pkg::SW_REBUILD
				&& !(start_s1 && j_s1 == J_LAST)) begin
			ovl_we    = 1'b1;
			ovl_waddr = {row_idx, j_s1};
			ovl_wdata = seg_val;
		end
	end

	assign rd_en   = cmd.read_idx || cmd.sweep_en;
	assign rd_addr = cmd.read_idx ? {row_idx, idx_q} : {row_idx, j_q};

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (rd_en) begin
			rec_rdata <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ovl_we) begin
			ovl_mem[ovl_waddr] <= ovl_wdata;
		end
		if (rd_en) begin
			ovl_rdata <= ovl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row       <= row_q;
			play_index    <= pacr_pkg::PLAY_W'(idx_q);
			record_value  <= rec_rdata;
			overlay_value <= ovl_rdata;
		end
	end

	always_comb begin
		status                = '0;
		status.command        = command_q;
		status.row_ok         = (int'(row_q) < ROWS);
		status.rebuild_needed = (eff_div != last_div_q[row_idx]);
		status.sweep_last     = (j_q == J_LAST);
		status.div_busy       = div_busy;
		status.init_last      = (clr_addr_q == CLR_LAST);
	end

endmodule

`default_nettype wire
